### hw/rtl/blw_pkg.sv
// ----------------------------------------------------------------------------
// blw_pkg
// Shared types and constants of the Bresenham line pixel walker.
// ----------------------------------------------------------------------------
package blw_pkg;

	// Field widths fixed by the framebuffer format.
	localparam int unsigned COORD_W   = 12;
	localparam int unsigned COLOR_W   = 24;
	localparam int unsigned ADDR_W    = 32;
	localparam int unsigned STRIDE_W  = 14;
	localparam int unsigned CFG_IDX_W = 1;

	// Default coordinate range (power of two).
	localparam int unsigned MAX_COORD_DFLT = 4096;

	// Bytes per pixel.
	localparam logic [ADDR_W-1:0] BYTES_PER_PIXEL = ADDR_W'(3);

	// Reset value of the row stride register.
	localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(3072);

	// Request types.
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE = 1'b1;

	// Vertical direction of the walk.
	localparam logic [1:0] MDIR_NONE = 2'd0;
	localparam logic [1:0] MDIR_INC  = 2'd1;
	localparam logic [1:0] MDIR_DEC  = 2'd2;

	// One emitted pixel.
	typedef struct packed {
		logic [ADDR_W-1:0]  address;
		logic [COLOR_W-1:0] color;
		logic               last;
	} blw_pix_t;

	// Walker status seen by the top level.
	typedef struct packed {
		logic busy;
		logic emit;
		logic last;
	} blw_status_t;

endpackage

### hw/rtl/blw_if.sv
// ----------------------------------------------------------------------------
// blw_if
// Valid/ready channels of the line walker: requests in, pixels out.
// ----------------------------------------------------------------------------
interface blw_req_if import blw_pkg::*;;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [COORD_W-1:0] start_x;
	logic [COORD_W-1:0] start_y;
	logic [COORD_W-1:0] end_x;
	logic [COORD_W-1:0] end_y;
	logic [COLOR_W-1:0] stroke_color;

	modport source (output valid, req_type, start_x, start_y, end_x, end_y,
		stroke_color, input ready);
	modport sink (input valid, req_type, start_x, start_y, end_x, end_y,
		stroke_color, output ready);
endinterface

interface blw_pix_if import blw_pkg::*;;
	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  pixel_address;
	logic [COLOR_W-1:0] pixel_color;
	logic               last_pixel;

	modport source (output valid, pixel_address, pixel_color, last_pixel,
		input ready);
	modport sink (input valid, pixel_address, pixel_color, last_pixel,
		output ready);
endinterface

### hw/rtl/blw_cfg_regs.sv
// ----------------------------------------------------------------------------
// blw_cfg_regs
// Frame base and row stride registers behind a plain write port.
// ----------------------------------------------------------------------------
module blw_cfg_regs import blw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_wdata,
	output logic [ADDR_W-1:0]    frame_base,
	output logic [STRIDE_W-1:0]  line_stride
);

	logic [ADDR_W-1:0]   frame_base_q;
	logic [STRIDE_W-1:0] line_stride_q;

	// Decode the index and capture the write data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q  <= '0;
			line_stride_q <= STRIDE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_BASE:  frame_base_q  <= cfg_wdata;
				REG_LINE_STRIDE: line_stride_q <= cfg_wdata[STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	assign frame_base  = frame_base_q;
	assign line_stride = line_stride_q;

endmodule

### hw/rtl/blw_walker.sv
// ----------------------------------------------------------------------------
// blw_walker
// Line setup on load and one Bresenham step per accepted advance request while a line is active.
// ----------------------------------------------------------------------------
module blw_walker import blw_pkg::*; #(
	parameter int unsigned MAX_COORD = MAX_COORD_DFLT
) (
	input  logic                clk,
	input  logic                arst_n,
	blw_req_if.sink             req,
	input  logic                slot_free,
	input  logic [ADDR_W-1:0]   frame_base,
	input  logic [STRIDE_W-1:0] line_stride,
	output blw_pix_t            pix_d,
	output blw_status_t         status
);

	localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'(MAX_COORD - 1);
	localparam int unsigned PROD_W = COORD_W + STRIDE_W;

	// The address is kept as two parts: column part (with frame base) and row part.
	logic [ADDR_W-1:0]  col_addr_q;
	logic [ADDR_W-1:0]  row_addr_q;
	logic [COORD_W-1:0] err_q;
	logic [COORD_W-1:0] left_q;
	logic [COORD_W-1:0] adx_q;
	logic [COORD_W-1:0] ady_q;
	logic [1:0]         mdir_q;
	logic               xmaj_q;
	logic [COLOR_W-1:0] color_q;
	logic               busy_q;

	logic               accept;
	logic               do_load;
	logic               do_step;

	// Load setup signals.
	logic [COORD_W-1:0] x0, y0, x1, y1;
	logic [COORD_W-1:0] sx, sy, ex, ey;
	logic [COORD_W-1:0] ld_adx, ld_ady;
	logic [1:0]         ld_mdir;
	logic               ld_xmaj;
	logic [COORD_W-1:0] ld_len;
	logic [PROD_W-1:0]  ld_prod;

	// Step signals.
	logic [ADDR_W-1:0]  vmove;
	logic [COORD_W:0]   err_sum;
	logic [COORD_W-1:0] minor_len;
	logic               minor_hit;
	logic [ADDR_W-1:0]  col_next;
	logic [ADDR_W-1:0]  row_next;

	assign accept    = req.valid && slot_free;
	assign do_load   = accept && (req.req_type == REQ_LOAD);
	assign do_step   = accept && (req.req_type == REQ_STEP) && busy_q;
	assign req.ready = slot_free;

	// Endpoint ordering, deltas and major axis for a new line.
	always_comb begin
		x0 = req.start_x & COORD_MASK;
		y0 = req.start_y & COORD_MASK;
		x1 = req.end_x & COORD_MASK;
		y1 = req.end_y & COORD_MASK;
		if (x1 < x0) begin
			sx = x1; sy = y1; ex = x0; ey = y0;
		end else begin
			sx = x0; sy = y0; ex = x1; ey = y1;
		end
		ld_adx = ex - sx;
		if (ey >= sy) begin
			ld_ady  = ey - sy;
			ld_mdir = (ey > sy) ? MDIR_INC : MDIR_NONE;
		end else begin
			ld_ady  = sy - ey;
			ld_mdir = MDIR_DEC;
		end
		ld_xmaj = (ld_adx >= ld_ady);
		ld_len  = ld_xmaj ? ld_adx : ld_ady;
		ld_prod = PROD_W'(sy) * PROD_W'(line_stride);
	end

	// One step: major move always, minor move when the error overflows.
	always_comb begin
		case (mdir_q)
			MDIR_INC: vmove = ADDR_W'(line_stride);
			MDIR_DEC: vmove = '0 - ADDR_W'(line_stride);
			default:  vmove = '0;
		endcase
		err_sum   = {1'b0, err_q} + {1'b0, (xmaj_q ? ady_q : adx_q)};
		minor_len = xmaj_q ? adx_q : ady_q;
		minor_hit = (err_sum >= {1'b0, minor_len});
		col_next  = col_addr_q;
		row_next  = row_addr_q;
		if (xmaj_q) begin
			col_next = col_addr_q + BYTES_PER_PIXEL;
			if (minor_hit) begin
				row_next = row_addr_q + vmove;
			end
		end else begin
			row_next = row_addr_q + vmove;
			if (minor_hit) begin
				col_next = col_addr_q + BYTES_PER_PIXEL;
			end
		end
	end

	// Busy flag, the only control state here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (do_load) begin
			busy_q <= (ld_len != '0);
		end else if (do_step) begin
			busy_q <= (left_q != COORD_W'(1));
		end
	end

	// Line state.
	always_ff @(posedge clk) begin
		if (do_load) begin
			col_addr_q <= frame_base + ADDR_W'({sx, 1'b0}) + ADDR_W'(sx);
			row_addr_q <= ADDR_W'(ld_prod);
			adx_q      <= ld_adx;
			ady_q      <= ld_ady;
			mdir_q     <= ld_mdir;
			xmaj_q     <= ld_xmaj;
			err_q      <= {1'b0, ld_len[COORD_W-1:1]};
			left_q     <= ld_len;
			color_q    <= req.stroke_color;
		end else if (do_step) begin
			col_addr_q <= col_next;
			row_addr_q <= row_next;
			err_q      <= minor_hit ? COORD_W'(err_sum - {1'b0, minor_len})
			                        : err_sum[COORD_W-1:0];
			left_q     <= left_q - COORD_W'(1);
		end
	end

	// Pixel of the current position, emitted before the step.
	assign pix_d.address = col_addr_q + row_addr_q;
	assign pix_d.color   = color_q;
	assign pix_d.last    = (left_q == COORD_W'(1));

	assign status.busy = busy_q;
	assign status.emit = do_step;
	assign status.last = pix_d.last;

endmodule

### hw/rtl/blw_out_reg.sv
// ----------------------------------------------------------------------------
// blw_out_reg
// Result register driving the pixel channel.
// ----------------------------------------------------------------------------
module blw_out_reg import blw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     emit,
	input  blw_pix_t pix_d,
	output logic     slot_free,
	blw_pix_if.source pix
);

	logic     valid_q;
	blw_pix_t data_q;

	// The register can take a result when empty or being drained this cycle.
	assign slot_free = !valid_q || pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit) begin
			valid_q <= 1'b1;
		end else if (pix.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			data_q <= pix_d;
		end
	end

	assign pix.valid         = valid_q;
	assign pix.pixel_address = data_q.address;
	assign pix.pixel_color   = data_q.color;
	assign pix.last_pixel    = data_q.last;

endmodule

### hw/rtl/bresenham_line_pixel_walker_top.sv
// A pixel appears on pix in the cycle after its advance request transfer.
// Throughput: one request per cycle; the request side stalls only while a
// finished pixel waits in the output register and pix.ready is low.
// Reset (arst_n low) clears the walker to idle, empties the output register,
// and sets frame base to zero and the row stride to 3072 bytes.
// ----------------------------------------------------------------------------
// bresenham_line_pixel_walker_top
// Line draw engine for a 24-bit framebuffer emitting one pixel address per step.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_walker_top import blw_pkg::*; #(
	parameter int unsigned MAX_COORD = MAX_COORD_DFLT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_wdata,
	blw_req_if.sink              req,
	blw_pix_if.source            pix
);

	logic [ADDR_W-1:0]   frame_base;
	logic [STRIDE_W-1:0] line_stride;
	logic                slot_free;
	blw_pix_t            pix_d;
	blw_status_t         status;

	// Configuration registers.
	blw_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.frame_base  (frame_base),
		.line_stride (line_stride)
	);

	// Line state and step logic.
	blw_walker #(
		.MAX_COORD (MAX_COORD)
	) u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.slot_free   (slot_free),
		.frame_base  (frame_base),
		.line_stride (line_stride),
		.pix_d       (pix_d),
		.status      (status)
	);

	// Output register.
	blw_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (status.emit),
		.pix_d     (pix_d),
		.slot_free (slot_free),
		.pix       (pix)
	);

`ifndef SYNTHESIS
	// An advance transfer while a line is active produces a pixel.
	a_step_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.req_type == REQ_STEP && status.busy)
		|=> pix.valid)
		else $error("advance on an active line produced no pixel");

	// The last pixel of a line leaves the walker idle.
	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(status.emit && status.last) |=> !status.busy)
		else $error("walker still busy after the last pixel");

	// An empty output register never stalls the request side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!pix.valid |-> req.ready)
		else $error("request stalled with an empty output register");

	// The pixel written to the output register carries the line's last flag.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		status.emit |=> (pix.last_pixel == $past(status.last)))
		else $error("last flag lost in the output register");
`endif

endmodule
